// ===== rtl/klenv_pkg.sv =====
`timescale 1ns / 1ps

package klenv_pkg;

  localparam int MAX_KEYS = 16;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  localparam int POS_W    = 24;
  localparam int LVL_W    = 16;
  localparam int LANES    = 4;
  localparam int LEVELS_W = LVL_W * LANES;
  localparam int ENTRY_W  = POS_W + LEVELS_W;
  localparam int FRAC_W   = 16;
  localparam int TIME_W   = 16;
  localparam int RATE_W   = 16;
  localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

  localparam logic [RATE_W-1:0] RATE_RESET   = 16'd3277;
  localparam logic [POS_W-1:0]  PROGRESS_MAX = 24'hFFFFFF;
  localparam logic [POS_W-1:0]  PROGRESS_ONE = 24'h010000;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] elapsed_time;
    logic [POS_W-1:0]  key_position;
    logic [LVL_W-1:0]  key_intensity;
    logic [LVL_W-1:0]  key_red;
    logic [LVL_W-1:0]  key_green;
    logic [LVL_W-1:0]  key_blue;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] out_intensity;
    logic [LVL_W-1:0] out_red;
    logic [LVL_W-1:0] out_green;
    logic [LVL_W-1:0] out_blue;
    logic             updated;
    logic             ended;
    logic             table_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROG,
    S_SCAN,
    S_DIV,
    S_LERP,
    S_DONE
  } state_t;

endpackage

// ===== rtl/klenv_ram.sv =====
`timescale 1ns / 1ps

module klenv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/klenv_div.sv =====
`timescale 1ns / 1ps

module klenv_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [klenv_pkg::POS_W-1:0]  num,
  input  logic [klenv_pkg::POS_W-1:0]  den,
  output logic                         done,
  output logic [klenv_pkg::FRAC_W-1:0] quo
);

  import klenv_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [POS_W-1:0]     rem_r;
  logic [POS_W-1:0]     den_r;
  logic [FRAC_W-1:0]    quo_r;
  logic [POS_W:0]       shifted;
  logic                 ge;
  logic [POS_W-1:0]     rem_nxt;

  always_comb begin
    shifted = {rem_r, 1'b0};
    ge      = shifted >= {1'b0, den_r};
    if (ge) begin
      rem_nxt = POS_W'(shifted - {1'b0, den_r});
    end else begin
      rem_nxt = shifted[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(FRAC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FRAC_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> rem_r < den_r)
    else $error("partial remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule

// ===== rtl/keyframe_light_envelope_core.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    klenv_pkg::in_item_t
// out_     output     out_valid / out_ready  klenv_pkg::out_item_t
// cfg_     input      cfg_valid / cfg_ready  progress rate, 16 bits
//
// Clear and append go from acceptance straight to S_DONE, which loads the result.
// A tick passes S_PROG, then S_SCAN, which steps through the keyframes via the table memory's
// read port when at least two are held, then S_DIV for the serial divider and S_LERP for the
// one-lane interpolation multiplier when the progress lies inside a segment, then S_DONE.
// One transaction is in work at a time; a result waiting in the output register stalls the
// block only when the next result is ready. Reset is synchronous and empties the table.

module keyframe_light_envelope_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  klenv_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output klenv_pkg::out_item_t         out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [klenv_pkg::RATE_W-1:0] cfg_data
);

  import klenv_pkg::*;

  state_t              state_r, state_nxt;
  logic [RATE_W-1:0]   rate_r;
  logic [CNT_W-1:0]    key_count_r;
  logic [POS_W-1:0]    progress_r;
  logic [LEVELS_W-1:0] held_r;
  logic                hit_r;
  logic                ovf_r;
  logic [ENTRY_W-1:0]  prev_r;
  logic [LEVELS_W-1:0] next_lvl_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic [1:0]          lane_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                in_fire;
  logic                table_full;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                div_start;
  logic                div_done;
  logic [FRAC_W-1:0]   div_quo;
  logic                out_free;
  logic                out_load;

  logic [2*TIME_W-1:0] gain_prod;
  logic [POS_W:0]      progress_sum;
  logic [POS_W-1:0]    progress_sat;
  logic [POS_W-1:0]    scan_pos;
  logic [LEVELS_W-1:0] scan_lvls;
  logic [POS_W-1:0]    prev_pos;
  logic                scan_found;
  logic                scan_last;
  logic                at_prev;
  logic [LVL_W-1:0]    lane_p;
  logic [LVL_W-1:0]    lane_n;
  logic signed [LVL_W:0]     lane_diff;
  logic signed [LVL_W:0]     lane_t;
  logic signed [2*LVL_W+1:0] lane_acc;
  logic [LVL_W-1:0]    lerp_val;

  klenv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_count_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  klenv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (progress_r - prev_pos),
    .den   (scan_pos - prev_pos),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    in_fire      = in_valid && in_ready;
    table_full   = key_count_r == CNT_W'(MAX_KEYS);
    ram_wdata    = {in_data.key_blue, in_data.key_green, in_data.key_red,
                    in_data.key_intensity, in_data.key_position};
    gain_prod    = in_data.elapsed_time * rate_r;
    progress_sum = {1'b0, progress_r} + (POS_W + 1)'(gain_prod[2*TIME_W-1:FRAC_W]);
    progress_sat = progress_sum[POS_W] ? PROGRESS_MAX : progress_sum[POS_W-1:0];
    scan_pos     = ram_rdata[POS_W-1:0];
    scan_lvls    = ram_rdata[ENTRY_W-1:POS_W];
    prev_pos     = prev_r[POS_W-1:0];
    scan_found   = (scan_idx_r != '0) && (progress_r < scan_pos);
    scan_last    = (CNT_W'(scan_idx_r) + CNT_W'(1)) == key_count_r;
    at_prev      = progress_r <= prev_pos;
    out_free     = !out_valid_r || out_ready;
  end

  always_comb begin
    lane_p    = prev_r[POS_W + LVL_W*lane_r +: LVL_W];
    lane_n    = next_lvl_r[LVL_W*lane_r +: LVL_W];
    lane_diff = $signed({1'b0, lane_n}) - $signed({1'b0, lane_p});
    lane_t    = $signed({1'b0, div_quo});
    lane_acc  = $signed({2'b00, lane_p, {FRAC_W{1'b0}}}) + lane_diff * lane_t;
    lerp_val  = lane_acc[LVL_W+FRAC_W-1:FRAC_W];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_data.action == ACT_TICK) ? S_PROG : S_DONE;
        end
      end
      S_PROG: begin
        state_nxt = (key_count_r < CNT_W'(2)) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (scan_found) begin
          state_nxt = at_prev ? S_DONE : S_DIV;
        end else if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_LERP;
        end
      end
      S_LERP: begin
        if (lane_r == 2'(LANES - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state_r == S_IDLE;
    cfg_ready = 1'b1;
    ram_we    = in_fire && (in_data.action == ACT_APPEND) && !table_full;
    ram_raddr = (state_r == S_SCAN) ? scan_idx_r + IDX_W'(1) : '0;
    div_start = (state_r == S_SCAN) && scan_found && !at_prev;
    out_load  = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= RATE_RESET;
      key_count_r <= '0;
      progress_r  <= '0;
      held_r      <= '0;
      hit_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        rate_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            hit_r <= 1'b0;
            ovf_r <= 1'b0;
            unique case (in_data.action)
              ACT_CLEAR: key_count_r <= '0;
              ACT_APPEND: begin
                if (table_full) begin
                  ovf_r <= 1'b1;
                end else begin
                  key_count_r <= key_count_r + CNT_W'(1);
                end
              end
              ACT_TICK: progress_r <= progress_sat;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_found) begin
            hit_r <= 1'b1;
            if (at_prev) begin
              held_r <= prev_r[ENTRY_W-1:POS_W];
            end
          end
        end
        S_LERP: held_r[LVL_W*lane_r +: LVL_W] <= lerp_val;
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_PROG: scan_idx_r <= '0;
      S_SCAN: begin
        lane_r <= '0;
        if (scan_found) begin
          next_lvl_r <= scan_lvls;
        end else begin
          prev_r     <= ram_rdata;
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
      end
      S_LERP: lane_r <= lane_r + 2'(1);
      default: ;
    endcase
    if (out_load) begin
      out_data_r.out_intensity  <= held_r[0*LVL_W +: LVL_W];
      out_data_r.out_red        <= held_r[1*LVL_W +: LVL_W];
      out_data_r.out_green      <= held_r[2*LVL_W +: LVL_W];
      out_data_r.out_blue       <= held_r[3*LVL_W +: LVL_W];
      out_data_r.updated        <= hit_r;
      out_data_r.ended          <= progress_r >= PROGRESS_ONE;
      out_data_r.table_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= CNT_W'(MAX_KEYS))
    else $error("key count beyond table depth");
  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CNT_W'(scan_idx_r) < key_count_r)
    else $error("scan beyond the written keyframes");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.updated && out_data_r.table_overflow))
    else $error("result marks both an update and an overflow");
  a_div_follows: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> state_r == S_DIV)
    else $error("division started outside the segment path");

endmodule

// ===== bench/keyframe_light_envelope_core_tb.sv =====
`timescale 1ns / 1ps

module keyframe_light_envelope_core_tb;
  import klenv_pkg::*;

  class light_envelope_scoreboard;
    logic [POS_W-1:0]  key_pos [MAX_KEYS];
    logic [LVL_W-1:0]  key_lvl [MAX_KEYS][LANES];
    int unsigned       key_count;
    logic [POS_W-1:0]  progress;
    logic [LVL_W-1:0]  held [LANES];
    logic [RATE_W-1:0] rate;
    out_item_t         expected_q [$];
    int                errors;
    int                items_seen;
    int                results_seen;
    int                updates_seen;
    int                overflows_seen;

    function new();
      key_count      = 0;
      progress       = '0;
      rate           = RATE_RESET;
      errors         = 0;
      items_seen     = 0;
      results_seen   = 0;
      updates_seen   = 0;
      overflows_seen = 0;
      foreach (held[k]) held[k] = '0;
    endfunction

    function void set_rate(logic [RATE_W-1:0] value);
      rate = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit seek_segment();
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic [63:0]      frac;
      logic [63:0]      mix;
      for (int i = 1; i < key_count; i++) begin
        lo = key_pos[i-1];
        hi = key_pos[i];
        if (progress < hi) begin
          if (progress <= lo) begin
            held = key_lvl[i-1];
          end else begin
            frac = (64'(progress - lo) << 16) / 64'(hi - lo);
            for (int k = 0; k < LANES; k++) begin
              mix = (64'(key_lvl[i-1][k]) * (64'd65536 - frac)
                     + 64'(key_lvl[i][k]) * frac) >> 16;
              held[k] = mix[LVL_W-1:0];
            end
          end
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_item(in_item_t it);
      out_item_t        exp;
      logic             hit;
      logic             dropped;
      logic [31:0]      gain;
      logic [POS_W:0]   sum;
      hit     = 1'b0;
      dropped = 1'b0;
      case (it.action)
        ACT_CLEAR: begin
          key_count = 0;
        end
        ACT_APPEND: begin
          if (key_count >= MAX_KEYS) begin
            dropped = 1'b1;
          end else begin
            key_pos[key_count]    = it.key_position;
            key_lvl[key_count][0] = it.key_intensity;
            key_lvl[key_count][1] = it.key_red;
            key_lvl[key_count][2] = it.key_green;
            key_lvl[key_count][3] = it.key_blue;
            key_count++;
          end
        end
        ACT_TICK: begin
          gain     = (32'(it.elapsed_time) * 32'(rate)) >> 16;
          sum      = progress + gain[POS_W-1:0];
          progress = (sum > PROGRESS_MAX) ? PROGRESS_MAX : sum[POS_W-1:0];
          hit      = seek_segment();
        end
        default: begin
        end
      endcase
      exp.out_intensity  = held[0];
      exp.out_red        = held[1];
      exp.out_green      = held[2];
      exp.out_blue       = held[3];
      exp.updated        = hit;
      exp.ended          = (progress >= PROGRESS_ONE);
      exp.table_overflow = dropped;
      expected_q = {expected_q, exp};
      items_seen++;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $error("Result transaction arrived with no expectation waiting");
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      results_seen++;
      if (exp.updated) updates_seen++;
      if (exp.table_overflow) overflows_seen++;
      compare_field("out_intensity", exp.out_intensity, got.out_intensity);
      compare_field("out_red", exp.out_red, got.out_red);
      compare_field("out_green", exp.out_green, got.out_green);
      compare_field("out_blue", exp.out_blue, got.out_blue);
      compare_field("updated", exp.updated, got.updated);
      compare_field("ended", exp.ended, got.ended);
      compare_field("table_overflow", exp.table_overflow, got.table_overflow);
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [RATE_W-1:0] cfg_data  = RATE_RESET;

  int idle_pct   = 0;
  int stall_left = 0;

  light_envelope_scoreboard sb = new();

  keyframe_light_envelope_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
      stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic in_item_t any_item(logic [1:0] act);
    in_item_t it;
    it.action        = act;
    it.elapsed_time  = TIME_W'($urandom);
    it.key_position  = POS_W'($urandom);
    it.key_intensity = LVL_W'($urandom);
    it.key_red       = LVL_W'($urandom);
    it.key_green     = LVL_W'($urandom);
    it.key_blue      = LVL_W'($urandom);
    return it;
  endfunction

  function automatic logic [LVL_W-1:0] pick_level();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return LVL_W'($urandom);
  endfunction

  function automatic logic [TIME_W-1:0] pick_elapsed(bit push);
    int roll;
    roll = $urandom_range(0, 99);
    if (push && roll < 80) return '1;
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return TIME_W'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(longint spot);
    if (spot < 0) return '0;
    if (spot > longint'(PROGRESS_MAX)) return PROGRESS_MAX;
    return POS_W'(spot);
  endfunction

  task automatic send_item(in_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_key(logic [POS_W-1:0] pos, logic [LVL_W-1:0] lv_i,
                          logic [LVL_W-1:0] lv_r, logic [LVL_W-1:0] lv_g,
                          logic [LVL_W-1:0] lv_b);
    in_item_t it;
    it               = any_item(ACT_APPEND);
    it.key_position  = pos;
    it.key_intensity = lv_i;
    it.key_red       = lv_r;
    it.key_green     = lv_g;
    it.key_blue      = lv_b;
    send_item(it);
  endtask

  task automatic send_tick(logic [TIME_W-1:0] elapsed);
    in_item_t it;
    it              = any_item(ACT_TICK);
    it.elapsed_time = elapsed;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_rate(value);
  endtask

  // A well-formed envelope is a clear, a run of keys placed around the current
  // progress, and then a random run of ticks to walk through them.
  task automatic run_envelope(bit push);
    int     roll;
    int     n_keys;
    int     step_max;
    longint spot;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      repeat ($urandom_range(1, 4)) send_item(any_item(2'($urandom_range(0, 3))));
      return;
    end
    send_item(any_item(ACT_CLEAR));
    roll = $urandom_range(0, 99);
    if (roll < 6) n_keys = $urandom_range(0, 1);
    else if (roll < 14) n_keys = $urandom_range(MAX_KEYS - 1, MAX_KEYS + 2);
    else n_keys = $urandom_range(2, 8);
    step_max = int'(sb.rate >> 1) + 64;
    spot = sb.progress;
    spot = clamp_pos(spot - int'($urandom_range(0, step_max)));
    repeat (n_keys) begin
      send_key(clamp_pos(spot), pick_level(), pick_level(), pick_level(), pick_level());
      roll = $urandom_range(0, 99);
      if (roll >= 15) spot = clamp_pos(spot + int'($urandom_range(1, step_max)));
      else if (roll >= 10) spot = clamp_pos(spot - int'($urandom_range(1, step_max)));
    end
    repeat ($urandom_range(1, n_keys + 3)) send_tick(pick_elapsed(push));
  endtask

  task automatic run_phase(logic [RATE_W-1:0] value, int pct, int item_goal);
    wait_drained();
    write_rate(value);
    idle_pct = pct;
    while (sb.items_seen < item_goal) run_envelope(1'b0);
  endtask

  initial begin
    in_item_t it;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 25;

    send_tick('0);
    it = '1;
    send_item(it);
    send_item(any_item(2'd3));
    send_key(24'h000100, '1, '1, '1, '1);
    send_tick('0);
    send_key(24'h000100, 16'h1234, 16'h8000, 16'h00FF, 16'hFF00);
    send_key(24'h000400, '0, '0, '0, '0);
    send_tick('0);
    send_tick(16'd5120);
    send_tick(16'd5120);
    send_tick('1);
    send_item(any_item(ACT_CLEAR));
    send_tick('0);
    send_key(PROGRESS_MAX, '1, '1, '1, '1);
    send_key(24'h800000, '0, '0, '0, '0);
    send_key('0, pick_level(), pick_level(), pick_level(), pick_level());
    send_tick('0);
    send_item(any_item(ACT_CLEAR));
    send_key('0, '0, '0, '0, '0);
    send_key(sb.progress + 24'd1, '1, '1, '1, '1);
    send_tick('0);

    run_phase('0, 30, 110);
    run_phase('1, 50, 245);
    run_phase(16'd1, 0, 320);
    run_phase(RATE_W'($urandom_range(2, 65534)), 20, 480);
    run_phase(RATE_RESET, 40, 600);

    wait_drained();
    write_rate('1);
    idle_pct = 0;
    while (sb.progress != PROGRESS_MAX || sb.items_seen < 1150) run_envelope(1'b1);

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Checked %0d results from %0d input transactions; %0d ticks refreshed the levels.",
             sb.results_seen, sb.items_seen, sb.updates_seen);
    $display("Appends dropped on a full table: %0d; progress finished at 0x%06h.",
             sb.overflows_seen, sb.progress);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
